// File: src/srr_pkg.sv
// Shared types and constants for the selective-repeat receiver.
// Used by srr_seq, srr_map and selective_repeat_receiver; no dependencies.
package srr_pkg;

    localparam int SEQ_BITS_MAX_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT = 2'd2;

    localparam logic [3:0]  SEQ_WIDTH_RST    = 4'd8;
    localparam logic [8:0]  WINDOW_LIMIT_RST = 9'd16;
    localparam logic [15:0] PACKET_LIMIT_RST = 16'd1000;

    localparam int TDATA_OUT_W = 32;

    typedef struct packed {
        logic [3:0]  seq_width;
        logic [8:0]  window_limit;
        logic [15:0] packet_limit;
    } t_cfg;

    typedef struct packed {
        logic       ack_valid;
        logic [7:0] ack_num;
        logic [8:0] delivered_now;
        logic [7:0] expected_next;
        logic       finished;
    } t_result;

endpackage

// File: src/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver, top level: config registers, output register.
// A frame passes from the input beat through evaluation, then a drain walk over held
// frames when it arrives in order and the packet limit is not yet reached, then the
// output register; output stalls hold the result back. One frame is in flight; the
// next beat is taken in the cycle after the result is loaded.
// Reset (synchronous, active low) clears state, then a pass over every entry wipes the bitmap.
module selective_repeat_receiver #(
    parameter int SEQ_BITS_MAX = srr_pkg::SEQ_BITS_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,  // [7:0] seq_num
    input  logic                                i_s_tuser,  // [0] lost
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] ack_num, [16:8] delivered_now, [24:17] expected_next, [25] finished
    output logic [srr_pkg::TDATA_OUT_W-1:0]     o_m_tdata,
    output logic                                o_m_tuser,  // [0] ack_valid
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [srr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [srr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    srr_pkg::t_cfg    r_cfg;
    srr_pkg::t_result w_result;
    logic             w_ready;
    logic             w_push;
    logic             w_out_free;
    logic             w_cfg_wr;
    logic             w_width_we;

    logic                            r_m_tvalid;
    logic [srr_pkg::TDATA_OUT_W-1:0] r_m_tdata;
    logic                            r_m_tuser;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;
    assign w_width_we  = w_cfg_wr && (i_cfg_index == srr_pkg::CFG_SEQ_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seq_width    <= srr_pkg::SEQ_WIDTH_RST;
            r_cfg.window_limit <= srr_pkg::WINDOW_LIMIT_RST;
            r_cfg.packet_limit <= srr_pkg::PACKET_LIMIT_RST;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                srr_pkg::CFG_SEQ_WIDTH:    r_cfg.seq_width    <= i_cfg_data[3:0];
                srr_pkg::CFG_WINDOW_LIMIT: r_cfg.window_limit <= i_cfg_data[8:0];
                srr_pkg::CFG_PACKET_LIMIT: r_cfg.packet_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    srr_seq #(.SEQ_BITS_MAX(SEQ_BITS_MAX)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_seq      (i_s_tdata),
        .i_lost     (i_s_tuser),
        .i_cfg      (r_cfg),
        .i_width_we (w_width_we),
        .i_width_new(i_cfg_data[3:0]),
        .i_out_free (w_out_free),
        .o_ready    (w_ready),
        .o_push     (w_push),
        .o_result   (w_result)
    );

    assign o_s_tready = w_ready;
    assign w_out_free = !r_m_tvalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_push) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_m_tdata <= {6'd0, w_result.finished, w_result.expected_next,
                          w_result.delivered_now, w_result.ack_num};
            r_m_tuser <= w_result.ack_valid;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

`ifndef SYNTH
    // one frame in flight: busy right after an input beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while a frame is in flight");

    // a result is only loaded into a free output slot
    a_push_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!r_m_tvalid || i_m_tready))
        else $error("result overwrote a pending output beat");

    // in-order delivery always comes with an ack
    a_deliver_acked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[16:8] != 9'd0)) |-> o_m_tuser)
        else $error("delivery without acknowledgement");
`endif

endmodule

// File: src/srr_map.sv
// Held-frame bitmap: one-bit memory, one write port, one registered read port.
// Depends on srr_pkg for its default width; cleared by the sequencer after reset.
module srr_map #(
    parameter int ADDR_W = srr_pkg::SEQ_BITS_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic              i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic              o_rdata
);
    localparam int DEPTH = 1 << ADDR_W;

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/srr_seq.sv
// Receiver sequencer: per-frame evaluation, drain walk over held frames,
// map clearing pass. Depends on srr_pkg and srr_map.
module srr_seq #(
    parameter int SEQ_BITS_MAX = srr_pkg::SEQ_BITS_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_seq,
    input  logic             i_lost,
    input  srr_pkg::t_cfg    i_cfg,
    input  logic             i_width_we,
    input  logic [3:0]       i_width_new,
    input  logic             i_out_free,
    output logic             o_ready,
    output logic             o_push,
    output srr_pkg::t_result o_result
);
    localparam int EW = SEQ_BITS_MAX;
    localparam int CW = (EW > 8) ? EW : 8;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [EW-1:0] r_clr, n_clr;
    logic [EW-1:0] r_expected, n_expected;
    logic [8:0]    r_count, n_count;
    logic [15:0]   r_total, n_total;
    logic          r_done, n_done;
    logic [7:0]    r_seq, n_seq;
    logic          r_lost, n_lost;
    logic          r_ack, n_ack;
    logic [8:0]    r_now, n_now;

    logic          map_we;
    logic [EW-1:0] map_waddr;
    logic          map_wdata;
    logic [EW-1:0] map_raddr;
    logic          map_rdata;

    logic [EW-1:0] mask;
    logic [EW-1:0] exp_inc;
    logic [15:0]   total_inc;
    logic          done_inc;
    logic [CW-1:0] seq_ext;
    logic [CW-1:0] exp_ext;
    logic          in_range;

    // mask of the effective width: 0 acts as 1, above EW acts as EW
    function automatic logic [EW-1:0] mask_of(input logic [3:0] w);
        logic [3:0] c;
        logic [EW:0] full;
        c = w;
        if (c == 4'd0) begin
            c = 4'd1;
        end
        if (c > 4'(EW)) begin
            c = 4'(EW);
        end
        full = ({{EW{1'b0}}, 1'b1} << c) - {{EW{1'b0}}, 1'b1};
        return full[EW-1:0];
    endfunction

    srr_map #(.ADDR_W(EW)) u_map (
        .i_clk  (i_clk),
        .i_we   (map_we),
        .i_waddr(map_waddr),
        .i_wdata(map_wdata),
        .i_raddr(map_raddr),
        .o_rdata(map_rdata)
    );

    // shared step unit: advance expected, bump total, check limit and seq range
    always_comb begin
        mask      = mask_of(i_cfg.seq_width);
        exp_inc   = (r_expected + {{(EW-1){1'b0}}, 1'b1}) & mask;
        total_inc = (r_total == 16'hFFFF) ? r_total : r_total + 16'd1;
        done_inc  = total_inc >= i_cfg.packet_limit;
        seq_ext   = CW'(r_seq);
        exp_ext   = CW'(r_expected);
        in_range  = (seq_ext & ~CW'(mask)) == '0;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_expected = r_expected;
        n_count    = r_count;
        n_total    = r_total;
        n_done     = r_done;
        n_seq      = r_seq;
        n_lost     = r_lost;
        n_ack      = r_ack;
        n_now      = r_now;
        map_we     = 1'b0;
        map_waddr  = r_expected;
        map_wdata  = 1'b0;
        map_raddr  = EW'(i_seq);
        o_push     = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                n_clr     = r_clr + {{(EW-1){1'b0}}, 1'b1};
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_seq   = i_seq;
                    n_lost  = i_lost;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_ack   = 1'b0;
                n_now   = 9'd0;
                n_state = S_OUT;
                if (!r_done && !r_lost && in_range) begin
                    if (seq_ext == exp_ext) begin
                        n_ack      = 1'b1;
                        n_now      = 9'd1;
                        n_expected = exp_inc;
                        n_total    = total_inc;
                        n_done     = done_inc;
                        map_raddr  = exp_inc;
                        if (!done_inc) begin
                            n_state = S_DRAIN;
                        end
                    end else if (seq_ext > exp_ext) begin
                        if (r_count < i_cfg.window_limit) begin
                            n_ack = 1'b1;
                            // rdata holds the entry read at accept time
                            if (!map_rdata) begin
                                map_we    = 1'b1;
                                map_waddr = EW'(r_seq);
                                map_wdata = 1'b1;
                                n_count   = r_count + 9'd1;
                            end
                        end
                    end
                end
            end
            S_DRAIN: begin
                // rdata is the entry at r_expected, read last cycle
                if (map_rdata) begin
                    map_we     = 1'b1;
                    map_waddr  = r_expected;
                    if (r_count != 9'd0) begin
                        n_count = r_count - 9'd1;
                    end
                    n_now      = r_now + 9'd1;
                    n_total    = total_inc;
                    n_done     = done_inc;
                    n_expected = exp_inc;
                    map_raddr  = exp_inc;
                    if (done_inc) begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // width rewrite reduces expected; the user must do it only while idle, the block has no check for it
        if (i_width_we) begin
            n_expected = r_expected & mask_of(i_width_new);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_expected <= '0;
            r_count    <= 9'd0;
            r_total    <= 16'd0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_expected <= n_expected;
            r_count    <= n_count;
            r_total    <= n_total;
            r_done     <= n_done;
            r_seq      <= n_seq;
            r_lost     <= n_lost;
            r_ack      <= n_ack;
            r_now      <= n_now;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_result.ack_valid     = r_ack;
        o_result.ack_num       = r_ack ? r_seq : 8'd0;
        o_result.delivered_now = r_now;
        o_result.expected_next = exp_ext[7:0];
        o_result.finished      = r_done;
    end

endmodule

// File: sim/tb.sv
// Testbench for selective_repeat_receiver: directed table, random retransmit bursts, closing limit phase.
// Each result is checked against an in-bench receiver model, or the table's want for typed rows.
// Depends on src/srr_pkg.sv and the receiver RTL.
`timescale 1ns / 100ps

module tb;

    localparam int SEQ_MAX    = srr_pkg::SEQ_BITS_MAX_DEF;
    localparam int LIMIT      = 2000000;
    localparam int PHASES     = 10;
    localparam int PHASE_ACKS = 45;
    localparam int MAX_PRINT  = 50;

    typedef enum bit {ROW_FRAME, ROW_REG} t_row_kind;

    // frame rows: a = seq_num, b = lost; register rows: a = index, b = value
    typedef struct {
        t_row_kind        kind;
        int               a;
        int               b;
        bit               typed;
        srr_pkg::t_result want;
    } t_dir_row;

    localparam srr_pkg::t_result NO_RESULT = '0;

    logic                                i_clk;
    logic                                i_rst_n     = 1'b0;
    logic                                i_s_tvalid  = 1'b0;
    logic                                o_s_tready;
    logic [7:0]                          i_s_tdata   = '0;
    logic                                i_s_tuser   = 1'b0;
    logic                                o_m_tvalid;
    logic                                i_m_tready  = 1'b0;
    logic [srr_pkg::TDATA_OUT_W-1:0]     o_m_tdata;
    logic                                o_m_tuser;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [srr_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [srr_pkg::CFG_DATA_W-1:0]      i_cfg_data  = '0;

    selective_repeat_receiver DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // receiver model state
    logic [3:0]  rx_width  = srr_pkg::SEQ_WIDTH_RST;
    logic [8:0]  rx_window = srr_pkg::WINDOW_LIMIT_RST;
    logic [15:0] rx_plimit = srr_pkg::PACKET_LIMIT_RST;
    int          exp_seq   = 0;
    bit          buffered [256];
    int          held_cnt  = 0;
    int          total_delivered = 0;
    bit          rx_done   = 1'b0;

    srr_pkg::t_result outcomes_due [$];
    t_dir_row    dir_steps [$];
    int          errors       = 0;
    int          results_seen = 0;
    int          acked_frames = 0;
    int          cycles       = 0;
    int          stall_left   = 0;
    bit          src_calm     = 1'b0;
    bit          sink_calm    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int seq_mod();
        int w;
        w = rx_width;
        if (w < 1) w = 1;
        if (w > SEQ_MAX) w = SEQ_MAX;
        return 1 << w;
    endfunction

    function automatic int gap_len(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void count_delivery();
        if (total_delivered < 65535) total_delivered++;
        if (total_delivered >= rx_plimit) rx_done = 1'b1;
    endfunction

    function automatic void reg_apply(input logic [srr_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [srr_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            srr_pkg::CFG_SEQ_WIDTH: begin
                rx_width = val[3:0];
                exp_seq &= seq_mod() - 1;
            end
            srr_pkg::CFG_WINDOW_LIMIT: rx_window = val[8:0];
            srr_pkg::CFG_PACKET_LIMIT: rx_plimit = val;
            default: ;
        endcase
    endfunction

    function automatic srr_pkg::t_result frame_outcome(input logic [7:0] seq,
                                                       input logic lost);
        srr_pkg::t_result r;
        int m;
        int now;
        m = seq_mod();
        r = '0;
        now = 0;
        if (!rx_done && !lost && seq < m) begin
            if (seq == exp_seq) begin
                r.ack_valid = 1'b1;
                r.ack_num = seq;
                exp_seq = (exp_seq + 1) & (m - 1);
                now = 1;
                count_delivery();
                // drain held frames that are now in order
                while (!rx_done && buffered[exp_seq]) begin
                    buffered[exp_seq] = 1'b0;
                    if (held_cnt > 0) held_cnt--;
                    now++;
                    count_delivery();
                    exp_seq = (exp_seq + 1) & (m - 1);
                end
            end else if (seq > exp_seq) begin
                if (held_cnt < rx_window) begin
                    if (!buffered[seq]) begin
                        buffered[seq] = 1'b1;
                        held_cnt++;
                    end
                    r.ack_valid = 1'b1;
                    r.ack_num = seq;
                end
            end
        end
        r.delivered_now = now[8:0];
        r.expected_next = exp_seq[7:0];
        r.finished = rx_done;
        return r;
    endfunction

    task automatic report(input string what, input int want, input int seen);
        if (errors < MAX_PRINT)
            $display("%0t ns: result %0d %s mismatch: expected %0d, got %0d",
                     $time, results_seen, what, want, seen);
        errors++;
    endtask

    task automatic send_frame(input logic [7:0] seq, input logic lost,
                              input bit typed = 1'b0,
                              input srr_pkg::t_result want = '0);
        srr_pkg::t_result r;
        int gap;
        gap = gap_len(src_calm);
        // release the config channel left asserted by the last register write
        if (i_cfg_valid) i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= seq;
        i_s_tuser  <= lost;
        do @(posedge i_clk); while (!o_s_tready);
        r = frame_outcome(seq, lost);
        if (r.ack_valid) acked_frames++;
        outcomes_due.push_back(typed ? want : r);
    endtask

    task automatic reg_write(input logic [srr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [srr_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_apply(idx, val);
    endtask

    task automatic drain_wait();
        i_s_tvalid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic retransmit_burst();
        int burst [8];
        int m;
        int len;
        int j;
        int t;
        m = seq_mod();
        len = $urandom_range(1, (m < 8) ? m : 8);
        for (int k = 0; k < len; k++)
            burst[k] = (exp_seq + k) & (m - 1);
        if ($urandom_range(0, 2) != 0) begin
            for (int k = len - 1; k > 0; k--) begin
                j = $urandom_range(0, k);
                t = burst[k];
                burst[k] = burst[j];
                burst[j] = t;
            end
        end
        for (int k = 0; k < len; k++) begin
            send_frame(burst[k][7:0], $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0)
                send_frame(burst[$urandom_range(0, len - 1)][7:0], 1'b0);
        end
    endtask

    task automatic noise_frame();
        logic [7:0] seq;
        if ($urandom_range(0, 1) != 0) seq = 8'($urandom_range(0, 255));
        else seq = 8'($urandom_range(0, seq_mod() - 1));
        send_frame(seq, 1'($urandom_range(0, 1)));
    endtask

    task automatic random_regs();
        int pick;
        int lim;
        pick = $urandom_range(0, 9);
        if (pick < 5) reg_write(srr_pkg::CFG_SEQ_WIDTH, 16'($urandom_range(2, 4)));
        else if (pick < 7) reg_write(srr_pkg::CFG_SEQ_WIDTH, 16'($urandom_range(0, 15)));
        else if (pick < 8) reg_write(srr_pkg::CFG_SEQ_WIDTH, 16'd1);
        else reg_write(srr_pkg::CFG_SEQ_WIDTH, 16'(SEQ_MAX));
        pick = $urandom_range(0, 9);
        if (pick == 0) reg_write(srr_pkg::CFG_WINDOW_LIMIT, 16'd1);
        else if (pick == 1) reg_write(srr_pkg::CFG_WINDOW_LIMIT, 16'd256);
        else if (pick == 2)
            reg_write(srr_pkg::CFG_WINDOW_LIMIT, 16'($urandom_range(0, 511)));
        else reg_write(srr_pkg::CFG_WINDOW_LIMIT, 16'($urandom_range(2, 24)));
        // keep the limit out of reach until the closing phase
        lim = total_delivered + 1000 + $urandom_range(0, 2000);
        if (lim > 65535 || $urandom_range(0, 4) == 0) lim = 65535;
        if ($urandom_range(0, 2) != 0) reg_write(srr_pkg::CFG_PACKET_LIMIT, 16'(lim));
    endtask

    // result side: random backpressure and field-by-field compare
    always @(posedge i_clk) begin
        srr_pkg::t_result want;
        if (o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (outcomes_due.size() == 0) begin
                report("unsolicited beat", 0, 1);
            end else begin
                want = outcomes_due.pop_front();
                if (o_m_tuser !== want.ack_valid)
                    report("ack_valid", want.ack_valid, o_m_tuser);
                if (o_m_tdata[7:0] !== want.ack_num)
                    report("ack_num", want.ack_num, o_m_tdata[7:0]);
                if (o_m_tdata[16:8] !== want.delivered_now)
                    report("delivered_now", want.delivered_now, o_m_tdata[16:8]);
                if (o_m_tdata[24:17] !== want.expected_next)
                    report("expected_next", want.expected_next, o_m_tdata[24:17]);
                if (o_m_tdata[25] !== want.finished)
                    report("finished", want.finished, o_m_tdata[25]);
            end
        end
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = gap_len(sink_calm);
        end
    end

    initial begin
        t_dir_row row;
        int goal;
        int base;

        dir_steps = '{
            '{ROW_FRAME, 0,   0, 1'b1, '{1'b1, 8'd0,   9'd1, 8'd1, 1'b0}},
            '{ROW_FRAME, 1,   1, 1'b1, '{1'b0, 8'd0,   9'd0, 8'd1, 1'b0}},
            '{ROW_FRAME, 255, 0, 1'b1, '{1'b1, 8'd255, 9'd0, 8'd1, 1'b0}},
            '{ROW_FRAME, 3,   0, 1'b0, NO_RESULT},
            '{ROW_FRAME, 3,   0, 1'b0, NO_RESULT},   // already held: re-ack
            '{ROW_FRAME, 2,   0, 1'b0, NO_RESULT},
            '{ROW_FRAME, 0,   0, 1'b0, NO_RESULT},   // stale
            '{ROW_FRAME, 1,   0, 1'b0, NO_RESULT},   // drains 2 and 3
            '{ROW_FRAME, 255, 1, 1'b0, NO_RESULT},
            '{ROW_REG,   srr_pkg::CFG_SEQ_WIDTH, 2, 1'b0, NO_RESULT},
            '{ROW_FRAME, 4,   0, 1'b1, '{1'b0, 8'd0,   9'd0, 8'd0, 1'b0}},
            '{ROW_FRAME, 2,   0, 1'b0, NO_RESULT},
            '{ROW_FRAME, 3,   0, 1'b0, NO_RESULT},
            '{ROW_FRAME, 0,   0, 1'b0, NO_RESULT},
            '{ROW_FRAME, 1,   0, 1'b0, NO_RESULT},   // drain wraps to 0
            '{ROW_REG,   srr_pkg::CFG_WINDOW_LIMIT, 1, 1'b0, NO_RESULT},
            '{ROW_FRAME, 2,   0, 1'b1, '{1'b0, 8'd0,   9'd0, 8'd0, 1'b0}},
            '{ROW_REG,   srr_pkg::CFG_WINDOW_LIMIT, 2, 1'b0, NO_RESULT},
            '{ROW_FRAME, 2,   0, 1'b0, NO_RESULT},
            '{ROW_FRAME, 2,   0, 1'b0, NO_RESULT},   // window full: no re-ack
            '{ROW_FRAME, 0,   0, 1'b0, NO_RESULT},
            '{ROW_FRAME, 1,   0, 1'b0, NO_RESULT},
            '{ROW_REG,   srr_pkg::CFG_SEQ_WIDTH, 0, 1'b0, NO_RESULT},    // acts as 1
            '{ROW_FRAME, 1,   0, 1'b0, NO_RESULT},
            '{ROW_REG,   srr_pkg::CFG_SEQ_WIDTH, 15, 1'b0, NO_RESULT},   // clamps to max
            '{ROW_REG,   srr_pkg::CFG_WINDOW_LIMIT, 256, 1'b0, NO_RESULT},
            '{ROW_REG,   srr_pkg::CFG_PACKET_LIMIT, 65535, 1'b0, NO_RESULT},
            '{ROW_FRAME, 128, 0, 1'b0, NO_RESULT}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_steps[i]) begin
            row = dir_steps[i];
            if (row.kind == ROW_REG) begin
                drain_wait();
                reg_write(srr_pkg::CFG_IDX_W'(row.a), srr_pkg::CFG_DATA_W'(row.b));
            end else begin
                send_frame(8'(row.a), 1'(row.b), row.typed, row.want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_wait();
            random_regs();
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            goal = acked_frames + PHASE_ACKS;
            while (acked_frames < goal) begin
                if ($urandom_range(0, 4) != 0) retransmit_burst();
                else noise_frame();
            end
        end

        // closing phase: hold frames, then set the limit so the drain stops short
        src_calm  = 1'b0;
        sink_calm = 1'b0;
        drain_wait();
        reg_write(srr_pkg::CFG_SEQ_WIDTH, 16'd1);
        reg_write(srr_pkg::CFG_SEQ_WIDTH, 16'(SEQ_MAX));
        reg_write(srr_pkg::CFG_WINDOW_LIMIT, 16'd256);
        base = exp_seq;
        for (int k = 1; k <= 4; k++) send_frame(8'(base + k), 1'b0);
        drain_wait();
        reg_write(srr_pkg::CFG_PACKET_LIMIT, 16'(total_delivered + 2));
        send_frame(8'(base), 1'b0);
        for (int k = 0; k < 8; k++) noise_frame();
        drain_wait();
        reg_write(srr_pkg::CFG_PACKET_LIMIT, 16'd1);
        for (int k = 0; k < 3; k++) noise_frame();

        drain_wait();
        repeat (16) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
